// ===== rtl/lgge_pkg.sv =====
// Shared types and constants for the life grid generation engine.
// No dependencies; every other rtl file refers to this package by scoped names.
package lgge_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [6:0] ACTIVE_COLS_RST = 7'd64;
  localparam logic [5:0] ACTIVE_ROWS_RST = 6'd32;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;
  localparam int unsigned NBR_COUNT    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_COLS = 1'b0,
    CFG_ACTIVE_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_GEN_START,
    S_LOAD_CUR,
    S_LOAD_NXT,
    S_CELL,
    S_WB,
    S_DONE
  } state_t;

  // 3x3 neighborhood handed to the rule unit
  typedef struct packed {
    logic [NBR_COUNT-1:0] nbr;
    logic                 self;
  } window_t;

endpackage

// ===== rtl/lgge_if.sv =====
// Request and response channel interfaces for the life grid engine.
// Depends on lgge_pkg for field widths.
interface lgge_in_if;
  logic                          valid;
  logic                          ready;
  logic [lgge_pkg::OP_W-1:0]     operation;
  logic [lgge_pkg::COL_W-1:0]    col;
  logic [lgge_pkg::ROW_W-1:0]    row;
  logic                          alive_in;

  modport source (output valid, operation, col, row, alive_in, input ready);
  modport sink   (input valid, operation, col, row, alive_in, output ready);
endinterface

interface lgge_out_if;
  logic valid;
  logic ready;
  logic alive_out;
  logic generation_advanced;

  modport source (output valid, alive_out, generation_advanced, input ready);
  modport sink   (input valid, alive_out, generation_advanced, output ready);
endinterface

// ===== rtl/lgge_rule_unit.sv =====
// Shared B3/S23 rule unit: counts the eight neighbors of one cell and decides its next state.
// Depends on lgge_pkg (window_t, rule counts).
module lgge_rule_unit (
  input  lgge_pkg::window_t win,
  output logic              next_alive
);

  logic [3:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < lgge_pkg::NBR_COUNT; i++) begin
      count = count + {3'b000, win.nbr[i]};
    end
  end

  assign next_alive = (count == lgge_pkg::BIRTH_COUNT) ||
                      (win.self && (count == lgge_pkg::SURVIVE_COUNT));

endmodule

// ===== rtl/life_grid_generation_engine_unit.sv =====
// Top level of the life grid engine: row memory, sequencer and response register.
// Depends on lgge_pkg, lgge_in_if / lgge_out_if and lgge_rule_unit.
//
//  channel     | dir | handshake          | payload
//  in_req      | in  | valid/ready        | operation, col, row, alive_in
//  out_resp    | out | valid/ready        | alive_out, generation_advanced
//  cfg_*       | in  | cfg_we, no ready   | cfg_index, cfg_wdata
//
// Cell write or read: accept, row memory access, response load.
// Tick that only flips parity: accept, response load. Generation tick: start, load the first
//   row, then for each row load the row below, one cell per cycle through the shared rule unit, write-back.
// Reset clears per-row valid bits, so no clearing pass runs; an unwritten row reads dead.
// A new request is taken as soon as the sequencer is back in idle, even if the last
// response still waits on out_resp.ready.
module life_grid_generation_engine_unit #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lgge_in_if.sink                           in_req,
  lgge_out_if.source                        out_resp,
  input  logic                              cfg_we,
  input  logic [lgge_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgge_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned CW    = $clog2(GRID_COLS);
  localparam int unsigned RW    = $clog2(GRID_ROWS);
  localparam int unsigned CCNT  = $clog2(GRID_COLS + 1);
  localparam int unsigned RCNT  = $clog2(GRID_ROWS + 1);
  localparam int unsigned RCNT1 = RCNT + 1;

  // configuration
  logic [6:0] cfg_cols_r;
  logic [5:0] cfg_rows_r;
  logic [CCNT-1:0] cols_eff_w;
  logic [RCNT-1:0] rows_eff_w;

  // sequencer
  lgge_pkg::state_t state_r, state_nxt;
  logic            parity_r;
  logic [1:0]      op_r;
  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic            alive_r;
  logic            res_alive_r;
  logic            res_gen_r;

  // generation window
  logic [GRID_COLS-1:0] prev_r, cur_r, nxt_r, new_row_r;
  logic [CW-1:0]        c_r;
  logic [RW-1:0]        r_r;

  // row memory
  logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid_r;
  logic [GRID_COLS-1:0] rdata_r;
  logic                 rd_live_r;
  logic [GRID_COLS-1:0] row_data_w;

  // response register
  logic out_valid_r, out_alive_r, out_gen_r;

  // control from the output decode
  logic [RW-1:0]        raddr_w;
  logic                 fetch_ok_w;
  logic                 mem_we_w;
  logic [RW-1:0]        waddr_w;
  logic [GRID_COLS-1:0] wdata_w;
  logic                 out_load_w;

  // decode helpers
  logic            accept_w;
  logic            inside_w;
  logic            is_access_w;
  logic            is_gen_w;
  logic            area_empty_w;
  logic            last_col_w;
  logic            last_row_w;
  logic [RCNT1-1:0] r_p1_w, r_p2_w;
  logic            left_ok_w, right_ok_w;
  logic [CW-1:0]   li_w, ri_w;
  lgge_pkg::window_t win_w;
  logic            cell_next_w;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= lgge_pkg::ACTIVE_COLS_RST;
      cfg_rows_r <= lgge_pkg::ACTIVE_ROWS_RST;
    end else if (cfg_we) begin
      unique case (lgge_pkg::cfg_idx_t'(cfg_index))
        lgge_pkg::CFG_ACTIVE_COLS: cfg_cols_r <= cfg_wdata;
        lgge_pkg::CFG_ACTIVE_ROWS: cfg_rows_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // saturate the active area to the grid
  assign cols_eff_w = (32'(cfg_cols_r) > GRID_COLS) ? CCNT'(GRID_COLS) : CCNT'(cfg_cols_r);
  assign rows_eff_w = (32'(cfg_rows_r) > GRID_ROWS) ? RCNT'(GRID_ROWS) : RCNT'(cfg_rows_r);
  assign area_empty_w = (cols_eff_w == '0) || (rows_eff_w == '0);

  // ---------------------------------------------------------------- decode
  assign accept_w    = in_req.valid && in_req.ready;
  assign inside_w    = (32'(in_req.col) < GRID_COLS) && (32'(in_req.row) < GRID_ROWS);
  assign is_access_w = ((in_req.operation == lgge_pkg::OP_WRITE) ||
                        (in_req.operation == lgge_pkg::OP_READ)) && inside_w;
  assign is_gen_w    = (in_req.operation == lgge_pkg::OP_TICK) && parity_r;

  assign last_col_w = (CCNT'(c_r) + CCNT'(1)) == cols_eff_w;
  assign last_row_w = (RCNT'(r_r) + RCNT'(1)) == rows_eff_w;
  assign r_p1_w     = RCNT1'(r_r) + RCNT1'(1);
  assign r_p2_w     = RCNT1'(r_r) + RCNT1'(2);

  assign row_data_w = rd_live_r ? rdata_r : '0;

  // neighborhood of cell c_r; columns outside the active area read dead
  assign left_ok_w  = (c_r != '0);
  assign right_ok_w = (CCNT'(c_r) + CCNT'(1)) < cols_eff_w;
  assign li_w       = left_ok_w  ? (c_r - CW'(1)) : c_r;
  assign ri_w       = right_ok_w ? (c_r + CW'(1)) : c_r;

  assign win_w.nbr  = {prev_r[li_w] & left_ok_w, prev_r[c_r], prev_r[ri_w] & right_ok_w,
                       cur_r[li_w]  & left_ok_w,               cur_r[ri_w]  & right_ok_w,
                       nxt_r[li_w]  & left_ok_w, nxt_r[c_r],  nxt_r[ri_w]  & right_ok_w};
  assign win_w.self = cur_r[c_r];

  lgge_rule_unit u_rule (
    .win        (win_w),
    .next_alive (cell_next_w)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lgge_pkg::S_IDLE: begin
        if (accept_w) begin
          priority if (is_access_w)                 state_nxt = lgge_pkg::S_ACCESS;
          else if (is_gen_w && !area_empty_w)       state_nxt = lgge_pkg::S_GEN_START;
          else                                      state_nxt = lgge_pkg::S_DONE;
        end
      end
      lgge_pkg::S_ACCESS:    state_nxt = lgge_pkg::S_DONE;
      lgge_pkg::S_GEN_START: state_nxt = lgge_pkg::S_LOAD_CUR;
      lgge_pkg::S_LOAD_CUR:  state_nxt = lgge_pkg::S_LOAD_NXT;
      lgge_pkg::S_LOAD_NXT:  state_nxt = lgge_pkg::S_CELL;
      lgge_pkg::S_CELL: begin
        if (last_col_w) state_nxt = lgge_pkg::S_WB;
      end
      lgge_pkg::S_WB: begin
        state_nxt = last_row_w ? lgge_pkg::S_DONE : lgge_pkg::S_LOAD_NXT;
      end
      lgge_pkg::S_DONE: begin
        if (out_load_w) state_nxt = lgge_pkg::S_IDLE;
      end
      default: state_nxt = lgge_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    raddr_w    = '0;
    fetch_ok_w = 1'b0;
    mem_we_w   = 1'b0;
    waddr_w    = row_r;
    wdata_w    = row_data_w;
    unique case (state_r)
      lgge_pkg::S_IDLE: begin
        raddr_w    = RW'(in_req.row);
        fetch_ok_w = 1'b1;
      end
      lgge_pkg::S_ACCESS: begin
        if (op_r == lgge_pkg::OP_WRITE) begin
          mem_we_w       = 1'b1;
          wdata_w[col_r] = alive_r;
        end
      end
      lgge_pkg::S_GEN_START: begin
        raddr_w    = '0;
        fetch_ok_w = 1'b1;
      end
      lgge_pkg::S_LOAD_CUR: begin
        raddr_w    = RW'(r_p1_w);
        fetch_ok_w = r_p1_w < RCNT1'(rows_eff_w);
      end
      lgge_pkg::S_WB: begin
        mem_we_w   = 1'b1;
        waddr_w    = r_r;
        wdata_w    = new_row_r;
        raddr_w    = RW'(r_p2_w);
        fetch_ok_w = r_p2_w < RCNT1'(rows_eff_w);
      end
      default: ;
    endcase
  end

  assign out_load_w = (state_r == lgge_pkg::S_DONE) && (!out_valid_r || out_resp.ready);
  assign in_req.ready = (state_r == lgge_pkg::S_IDLE);

  // ---------------------------------------------------------------- row memory
  always_ff @(posedge clk) begin
    if (mem_we_w) grid_mem[waddr_w] <= wdata_w;
    rdata_r <= grid_mem[raddr_w];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_live_r   <= 1'b0;
    end else begin
      if (mem_we_w) row_valid_r[waddr_w] <= 1'b1;
      rd_live_r <= fetch_ok_w && row_valid_r[raddr_w];
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgge_pkg::S_IDLE;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept_w && (in_req.operation == lgge_pkg::OP_TICK)) parity_r <= !parity_r;
      if (out_load_w)              out_valid_r <= 1'b1;
      else if (out_resp.ready)     out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept_w) begin
      op_r        <= in_req.operation;
      col_r       <= CW'(in_req.col);
      row_r       <= RW'(in_req.row);
      alive_r     <= in_req.alive_in;
      res_alive_r <= 1'b0;
      res_gen_r   <= is_gen_w;
    end

    unique case (state_r)
      lgge_pkg::S_ACCESS: begin
        if (op_r == lgge_pkg::OP_READ) res_alive_r <= row_data_w[col_r];
      end
      lgge_pkg::S_GEN_START: begin
        prev_r <= '0;
        r_r    <= '0;
      end
      lgge_pkg::S_LOAD_CUR: cur_r <= row_data_w;
      lgge_pkg::S_LOAD_NXT: begin
        nxt_r     <= row_data_w;
        new_row_r <= cur_r;   // columns past the active area keep their value
        c_r       <= '0;
      end
      lgge_pkg::S_CELL: begin
        new_row_r[c_r] <= cell_next_w;
        c_r            <= c_r + CW'(1);
      end
      lgge_pkg::S_WB: begin
        prev_r <= cur_r;
        cur_r  <= nxt_r;
        r_r    <= r_p1_w[RW-1:0];
      end
      default: ;
    endcase

    if (out_load_w) begin
      out_alive_r <= res_alive_r;
      out_gen_r   <= res_gen_r;
    end
  end

  assign out_resp.valid               = out_valid_r;
  assign out_resp.alive_out           = out_alive_r;
  assign out_resp.generation_advanced = out_gen_r;

  // ---------------------------------------------------------------- assertions
  a_mem_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we_w |-> (state_r == lgge_pkg::S_ACCESS || state_r == lgge_pkg::S_WB))
    else $error("row memory written outside access or write-back");

  a_col_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgge_pkg::S_CELL) |-> (CCNT'(c_r) < cols_eff_w))
    else $error("cell column left the active area");

  a_row_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgge_pkg::S_WB) |-> (RCNT'(r_r) < rows_eff_w))
    else $error("write-back row left the active area");

  a_gen_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgge_pkg::S_DONE && res_gen_r) |-> !parity_r)
    else $error("generation reported with tick parity odd");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept_w |=> (state_r != lgge_pkg::S_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule

// ===== dv/tb_life_grid_generation_engine_unit.sv =====
`timescale 1ns / 100ps
// Testbench for life_grid_generation_engine_unit: directed and random cell requests,
// checked against a Game of Life grid model kept in a small scoreboard class.
// Depends on lgge_pkg and the lgge_in_if / lgge_out_if interfaces from rtl.
module tb_life_grid_generation_engine_unit;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 32;
  localparam int unsigned OP_W  = lgge_pkg::OP_W;
  localparam int unsigned COL_W = lgge_pkg::COL_W;
  localparam int unsigned ROW_W = lgge_pkg::ROW_W;
  localparam int unsigned CFG_W = lgge_pkg::CFG_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    bit alive;
    bit advanced;
  } reply_t;

  typedef struct {
    int unsigned cols;
    int unsigned rows;
    idle_mode_t  mode;
    int unsigned items;
    bit          squeeze;
  } phase_t;

  class life_grid_tracker;
    bit          cells [GRID_ROWS][GRID_COLS];
    bit          parity;
    int unsigned area_cols;
    int unsigned area_rows;
    reply_t      pending_replies [$];
    int unsigned mismatches;

    function void clear();
      foreach (cells[r, c]) cells[r][c] = 1'b0;
      parity = 1'b0;
      area_cols = 32'(lgge_pkg::ACTIVE_COLS_RST);
      area_rows = 32'(lgge_pkg::ACTIVE_ROWS_RST);
      mismatches = 0;
      pending_replies.delete();
    endfunction

    function void set_reg(lgge_pkg::cfg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == lgge_pkg::CFG_ACTIVE_COLS)
        area_cols = 32'(value);
      else
        area_rows = 32'(value[5:0]);
    endfunction

    function int eff_cols();
      return (area_cols > GRID_COLS) ? GRID_COLS : area_cols;
    endfunction

    function int eff_rows();
      return (area_rows > GRID_ROWS) ? GRID_ROWS : area_rows;
    endfunction

    // Anything outside the active area counts as dead
    function int live_at(int r, int c, int er, int ec);
      if (r < 0 || c < 0 || r >= er || c >= ec)
        return 0;
      return cells[r][c];
    endfunction

    function void step_generation();
      bit nxt [GRID_ROWS][GRID_COLS];
      int ec;
      int er;
      int n;
      ec = eff_cols();
      er = eff_rows();
      for (int r = 0; r < er; r++) begin
        for (int c = 0; c < ec; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0)
                n += live_at(r + dr, c + dc, er, ec);
          if (cells[r][c])
            nxt[r][c] = (n == lgge_pkg::SURVIVE_COUNT || n == lgge_pkg::BIRTH_COUNT);
          else
            nxt[r][c] = (n == lgge_pkg::BIRTH_COUNT);
        end
      end
      for (int r = 0; r < er; r++)
        for (int c = 0; c < ec; c++)
          cells[r][c] = nxt[r][c];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row, logic alive);
      reply_t rep;
      rep.alive = 1'b0;
      rep.advanced = 1'b0;
      case (op)
        lgge_pkg::OP_WRITE: cells[row][col] = alive;
        lgge_pkg::OP_READ:  rep.alive = cells[row][col];
        lgge_pkg::OP_TICK: begin
          parity ^= 1'b1;
          if (!parity) begin
            step_generation();
            rep.advanced = 1'b1;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(rep);
    endfunction

    function void check_response(logic alive, logic advanced);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response with nothing outstanding: alive_out=%b advanced=%b",
                   $realtime, alive, advanced);
        return;
      end
      want = pending_replies.pop_front();
      if (alive !== want.alive || advanced !== want.advanced) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: expected alive_out=%b advanced=%b, got %b %b",
                   $realtime, want.alive, want.advanced, alive, advanced);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  lgge_pkg::cfg_idx_t  cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  lgge_in_if  in_ch ();
  lgge_out_if out_ch ();

  life_grid_tracker tracker;
  idle_mode_t       idle_mode = IDLE_NONE;
  bit               hold_off = 1'b0;
  int unsigned      cycle_count = 0;
  event             hold_off_start;

  phase_t plan [11] = '{
    '{8,   6,  IDLE_NONE, 110, 1'b0},
    '{16,  10, IDLE_SEND, 100, 1'b0},
    '{1,   1,  IDLE_RECV, 40,  1'b0},
    '{64,  32, IDLE_BOTH, 60,  1'b0},
    '{5,   32, IDLE_NONE, 60,  1'b0},
    '{64,  1,  IDLE_SEND, 60,  1'b0},
    '{12,  8,  IDLE_RECV, 100, 1'b1},
    '{100, 40, IDLE_BOTH, 40,  1'b0},
    '{3,   3,  IDLE_BOTH, 80,  1'b0},
    '{20,  0,  IDLE_NONE, 30,  1'b0},
    '{10,  7,  IDLE_RECV, 70,  1'b0}
  };

  life_grid_generation_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_resp  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL life_grid_generation_engine_unit");
      $finish;
    end
  end

  function int unsigned send_gap_pct();
    case (idle_mode)
      IDLE_SEND: return 48;
      IDLE_BOTH: return 32;
      default:   return 0;
    endcase
  endfunction

  function int unsigned recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 48;
      IDLE_BOTH: return 32;
      default:   return 0;
    endcase
  endfunction

  // Sample the response handshake first, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_response(out_ch.alive_out, out_ch.generation_advanced);
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct());
  end

  initial begin
    @(hold_off_start);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic offer_request(logic [OP_W-1:0] op, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row, logic alive);
    while ($urandom_range(99) < send_gap_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.col       <= col;
    in_ch.row       <= row;
    in_ch.alive_in  <= alive;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(op, col, row, alive);
  endtask

  // Drop valid, then let every outstanding response drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_area(int unsigned cols, int unsigned rows);
    cfg_we    <= 1'b1;
    cfg_index <= lgge_pkg::CFG_ACTIVE_COLS;
    cfg_wdata <= cols[CFG_W-1:0];
    tracker.set_reg(lgge_pkg::CFG_ACTIVE_COLS, cols[CFG_W-1:0]);
    @(posedge clk);
    cfg_index <= lgge_pkg::CFG_ACTIVE_ROWS;
    cfg_wdata <= rows[CFG_W-1:0];
    tracker.set_reg(lgge_pkg::CFG_ACTIVE_ROWS, rows[CFG_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly inside the active area, now and then anywhere on the grid
  function logic [COL_W-1:0] pick_col();
    int ec;
    ec = tracker.eff_cols();
    if (ec == 0 || $urandom_range(9) == 0)
      return COL_W'($urandom_range(GRID_COLS - 1));
    return COL_W'($urandom_range(ec - 1));
  endfunction

  function logic [ROW_W-1:0] pick_row();
    int er;
    er = tracker.eff_rows();
    if (er == 0 || $urandom_range(9) == 0)
      return ROW_W'($urandom_range(GRID_ROWS - 1));
    return ROW_W'($urandom_range(er - 1));
  endfunction

  // Seed a pattern, run a few generations, sample cells, sprinkle noise
  task automatic run_rounds(int unsigned items);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(12, 3);
      repeat (n) begin
        offer_request(lgge_pkg::OP_WRITE, pick_col(), pick_row(), $urandom_range(99) < 60);
        sent++;
      end
      n = ($urandom_range(7) == 0) ? 1 : 2 * $urandom_range(2, 1);
      repeat (n) begin
        offer_request(lgge_pkg::OP_TICK, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
        sent++;
      end
      n = $urandom_range(8, 3);
      repeat (n) begin
        offer_request(lgge_pkg::OP_READ, pick_col(), pick_row(), 1'($urandom));
        sent++;
      end
      if ($urandom_range(4) == 0) begin
        offer_request(OP_UNUSED, COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    tracker = new;
    tracker.clear();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = lgge_pkg::CFG_ACTIVE_COLS;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = lgge_pkg::OP_WRITE;
    in_ch.col       = '0;
    in_ch.row       = '0;
    in_ch.alive_in  = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid, opposite corners, a blinker, the unused code and one generation
    offer_request(lgge_pkg::OP_READ, 0, 0, 0);
    offer_request(lgge_pkg::OP_WRITE, 0, 0, 1);
    offer_request(lgge_pkg::OP_WRITE, 63, 31, 1);
    offer_request(lgge_pkg::OP_READ, 0, 0, 0);
    offer_request(lgge_pkg::OP_READ, 63, 31, 0);
    offer_request(lgge_pkg::OP_WRITE, 2, 1, 1);
    offer_request(lgge_pkg::OP_WRITE, 3, 1, 1);
    offer_request(lgge_pkg::OP_WRITE, 4, 1, 1);
    offer_request(OP_UNUSED, 63, 31, 1);
    offer_request(lgge_pkg::OP_TICK, 0, 0, 0);
    offer_request(lgge_pkg::OP_TICK, 63, 31, 1);
    offer_request(lgge_pkg::OP_READ, 3, 0, 0);
    offer_request(lgge_pkg::OP_READ, 3, 2, 1);
    offer_request(lgge_pkg::OP_READ, 2, 1, 0);
    offer_request(lgge_pkg::OP_READ, 0, 0, 1);

    // Empty active area: the generation tick must leave cells alone
    wait_idle();
    write_area(0, 32);
    offer_request(lgge_pkg::OP_WRITE, 5, 5, 1);
    offer_request(lgge_pkg::OP_TICK, 0, 0, 0);
    offer_request(lgge_pkg::OP_TICK, 0, 0, 0);
    offer_request(lgge_pkg::OP_READ, 5, 5, 0);

    // Oversized area saturates to the full grid
    wait_idle();
    write_area(127, 63);
    offer_request(lgge_pkg::OP_TICK, 0, 0, 0);
    offer_request(lgge_pkg::OP_TICK, 0, 0, 0);
    offer_request(lgge_pkg::OP_READ, 5, 5, 0);
    offer_request(lgge_pkg::OP_READ, 2, 1, 0);

    foreach (plan[i]) begin
      wait_idle();
      write_area(plan[i].cols, plan[i].rows);
      idle_mode = plan[i].mode;
      // Stall responses for a long stretch so requests back up at the input
      if (plan[i].squeeze)
        -> hold_off_start;
      run_rounds(plan[i].items);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
      $display("PASS life_grid_generation_engine_unit");
    else
      $display("FAIL life_grid_generation_engine_unit");
    $finish;
  end

endmodule
